@@ hdl/sdoq_pkg.sv @@
`default_nettype none
package sdoq_pkg;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_UPDATE = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_DUMP   = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   // Register index of overdraw_mode, taken from paddr[2].
   localparam logic CSR_IDX_OVERDRAW = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RESP,
      ST_SC_RD,
      ST_SC_CK,
      ST_SU_RD,
      ST_SU_WR,
      ST_SD_RD,
      ST_SD_WR,
      ST_FD_RD,
      ST_FD_CK,
      ST_NL_RD,
      ST_NL_CK,
      ST_NH_RD,
      ST_NH_CK,
      ST_RM_RD,
      ST_RM_CK,
      ST_DP_RD,
      ST_DP_OUT
   } state_type;

endpackage
`default_nettype wire

@@ hdl/sdoq_req_if.sv @@
`default_nettype none
interface sdoq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] handle;
   logic [15:0] draw_order;
   logic        is_debug;

   modport source (output valid, kind, handle, draw_order, is_debug, input ready);
   modport sink (input valid, kind, handle, draw_order, is_debug, output ready);
endinterface
`default_nettype wire

@@ hdl/sdoq_rsp_if.sv @@
`default_nettype none
interface sdoq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] handle_out;
   logic [1:0]  status;
   logic        last;
   logic [5:0]  entry_count;

   modport source (output valid, handle_out, status, last, entry_count, input ready);
   modport sink (input valid, handle_out, status, last, entry_count, output ready);
endinterface
`default_nettype wire

@@ hdl/sdoq_ram.sv @@
`default_nettype none
module sdoq_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/sdoq_csr.sv @@
`default_nettype none
module sdoq_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        overdraw_mode
);
   import sdoq_pkg::*;

   logic mode_ff;
   logic mode_in;
   logic hit;

   // Byte address 0 holds the only register; paddr[2] selects beyond it.
   assign hit = (paddr[2] == CSR_IDX_OVERDRAW);

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && hit) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign prdata        = hit ? {31'd0, mode_ff} : 32'd0;
   assign pready        = 1'b1;
   assign overdraw_mode = mode_ff;

endmodule
`default_nettype wire

@@ hdl/sorted_draw_order_queue.sv @@
`default_nettype none
// Items are handled one at a time: no new request is taken until the result of the
// last one has been presented. Insert scans for the new place, then shifts; remove
// packs the survivors down; update finds the entry, then scans for a new place and
// shifts if needed; clear and items rejected on arrival go straight to the response;
// a dump gives one entry per response. Reset (synchronous) empties the table and
// clears overdraw mode at once; the memory is left as it is.
module sorted_draw_order_queue #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   sdoq_req_if.sink    req_ch,
   sdoq_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sdoq_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 16 + KEY_WIDTH + 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

   // Entry layout: handle on top, then order, debug flag in bit 0.
   function automatic logic [KEY_WIDTH:0] key_of(input logic [EW-1:0] e, input logic m);
      return m ? {e[0], e[KEY_WIDTH:1]} : e[KEY_WIDTH:0];
   endfunction

   function automatic logic below(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                  input logic m);
      return key_of(a, m) < key_of(b, m);
   endfunction

   logic overdraw_mode;

   sdoq_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .overdraw_mode (overdraw_mode)
   );

   logic          we;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic          re;
   logic [AW-1:0] raddr;
   logic [EW-1:0] rdata;

   sdoq_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   state_type     state_ff, state_in;
   logic [2:0]    kind_ff, kind_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] fnd_ff, fnd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          up_ff, up_in;
   logic [1:0]    stat_ff, stat_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_handle_ff, rsp_handle_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [5:0]    rsp_count_ff, rsp_count_in;

   logic          can_load;
   logic [CW-1:0] idx_p1, idx_m1, fnd_p1, fnd_m1;
   logic          scan_done;

   assign can_load = !rsp_valid_ff || rsp_ch.ready;
   assign idx_p1   = idx_ff + CW'(1);
   assign idx_m1   = idx_ff - CW'(1);
   assign fnd_p1   = fnd_ff + CW'(1);
   assign fnd_m1   = fnd_ff - CW'(1);

   // Reads and writes alternate, so a read never meets a write to the same
   // entry in flight and no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      ent_in        = ent_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      fnd_in        = fnd_ff;
      cnt_in        = cnt_ff;
      up_in         = up_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      we            = 1'b0;
      waddr         = idx_ff[AW-1:0];
      wdata         = ent_ff;
      re            = 1'b0;
      raddr         = idx_ff[AW-1:0];
      req_ch.ready  = 1'b0;
      scan_done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               kind_in = req_ch.kind;
               ent_in  = {req_ch.handle, KEY_WIDTH'(req_ch.draw_order), req_ch.is_debug};
               idx_in  = '0;
               pos_in  = '0;
               stat_in = STAT_OK;
               unique case (req_ch.kind)
                  KIND_INSERT: begin
                     if (cnt_ff == FULL_CNT) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else begin
                        end_in   = cnt_ff;
                        up_in    = 1'b1;
                        state_in = ST_SC_RD;
                     end
                  end
                  KIND_UPDATE: state_in = ST_FD_RD;
                  KIND_REMOVE: state_in = ST_RM_RD;
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_RESP;
                  end
                  KIND_DUMP: begin
                     if (cnt_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_DP_RD;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RESP: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_status_in = stat_ff;
               rsp_last_in   = 1'b1;
               rsp_count_in  = 6'(cnt_ff);
               state_in      = ST_IDLE;
            end
         end
         ST_SC_RD: begin
            if (idx_ff == end_ff) begin
               pos_in    = end_ff;
               scan_done = 1'b1;
            end else begin
               re       = 1'b1;
               state_in = ST_SC_CK;
            end
         end
         ST_SC_CK: begin
            if (below(ent_ff, rdata, overdraw_mode)) begin
               pos_in    = idx_ff;
               scan_done = 1'b1;
            end else begin
               idx_in   = idx_p1;
               state_in = ST_SC_RD;
            end
         end
         ST_SU_RD: begin
            if (idx_ff == pos_ff) begin
               we    = 1'b1;
               waddr = pos_ff[AW-1:0];
               if (kind_ff == KIND_INSERT) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               state_in = ST_RESP;
            end else begin
               re       = 1'b1;
               raddr    = idx_m1[AW-1:0];
               state_in = ST_SU_WR;
            end
         end
         ST_SU_WR: begin
            we       = 1'b1;
            wdata    = rdata;
            idx_in   = idx_m1;
            state_in = ST_SU_RD;
         end
         ST_SD_RD: begin
            if (idx_p1 == pos_ff) begin
               we       = 1'b1;
               state_in = ST_RESP;
            end else begin
               re       = 1'b1;
               raddr    = idx_p1[AW-1:0];
               state_in = ST_SD_WR;
            end
         end
         ST_SD_WR: begin
            we       = 1'b1;
            wdata    = rdata;
            idx_in   = idx_p1;
            state_in = ST_SD_RD;
         end
         ST_FD_RD: begin
            if (idx_ff == cnt_ff) begin
               stat_in  = STAT_NOTFOUND;
               state_in = ST_RESP;
            end else begin
               re       = 1'b1;
               state_in = ST_FD_CK;
            end
         end
         ST_FD_CK: begin
            if (rdata[EW-1:KEY_WIDTH+1] == ent_ff[EW-1:KEY_WIDTH+1]) begin
               fnd_in   = idx_ff;
               ent_in   = {rdata[EW-1:KEY_WIDTH+1], ent_ff[KEY_WIDTH:1], rdata[0]};
               state_in = ST_NL_RD;
            end else begin
               idx_in   = idx_p1;
               state_in = ST_FD_RD;
            end
         end
         ST_NL_RD: begin
            if (fnd_ff == '0) begin
               state_in = ST_NH_RD;
            end else begin
               re       = 1'b1;
               raddr    = fnd_m1[AW-1:0];
               state_in = ST_NL_CK;
            end
         end
         ST_NL_CK: begin
            if (below(ent_ff, rdata, overdraw_mode)) begin
               idx_in   = '0;
               end_in   = fnd_ff;
               up_in    = 1'b1;
               state_in = ST_SC_RD;
            end else begin
               state_in = ST_NH_RD;
            end
         end
         ST_NH_RD: begin
            if (fnd_p1 >= cnt_ff) begin
               we       = 1'b1;
               waddr    = fnd_ff[AW-1:0];
               state_in = ST_RESP;
            end else begin
               re       = 1'b1;
               raddr    = fnd_p1[AW-1:0];
               state_in = ST_NH_CK;
            end
         end
         ST_NH_CK: begin
            if (below(rdata, ent_ff, overdraw_mode)) begin
               idx_in   = fnd_p1;
               end_in   = cnt_ff;
               up_in    = 1'b0;
               state_in = ST_SC_RD;
            end else begin
               we       = 1'b1;
               waddr    = fnd_ff[AW-1:0];
               state_in = ST_RESP;
            end
         end
         ST_RM_RD: begin
            if (idx_ff == cnt_ff) begin
               cnt_in   = pos_ff;
               state_in = ST_RESP;
            end else begin
               re       = 1'b1;
               state_in = ST_RM_CK;
            end
         end
         ST_RM_CK: begin
            // Survivors are packed down; the write slot never passes the read.
            if (rdata[EW-1:KEY_WIDTH+1] != ent_ff[EW-1:KEY_WIDTH+1]) begin
               we     = 1'b1;
               waddr  = pos_ff[AW-1:0];
               wdata  = rdata;
               pos_in = pos_ff + CW'(1);
            end
            idx_in   = idx_p1;
            state_in = ST_RM_RD;
         end
         ST_DP_RD: begin
            re       = 1'b1;
            state_in = ST_DP_OUT;
         end
         ST_DP_OUT: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = rdata[EW-1:KEY_WIDTH+1];
               rsp_status_in = STAT_OK;
               rsp_last_in   = (idx_p1 == cnt_ff);
               rsp_count_in  = 6'(cnt_ff);
               idx_in        = idx_p1;
               state_in      = (idx_p1 == cnt_ff) ? ST_IDLE : ST_DP_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // An up shift after a scan runs from the top of the moved range, a down shift from its bottom.
      if (scan_done) begin
         if (up_ff) begin
            idx_in   = (kind_ff == KIND_INSERT) ? cnt_ff : fnd_ff;
            state_in = ST_SU_RD;
         end else begin
            idx_in   = fnd_ff;
            state_in = ST_SD_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ent_ff        <= ent_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      fnd_ff        <= fnd_in;
      up_ff         <= up_in;
      stat_ff       <= stat_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.handle_out  = rsp_handle_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("entry count beyond table depth");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == STAT_FULL) |-> rsp_ch.entry_count == 6'(FULL_CNT))
      else $error("table full reported while not full");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.kind == KIND_CLEAR) |=> cnt_ff == '0)
      else $error("clear did not empty the table");

   a_dump_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DP_OUT) && can_load && (idx_p1 == cnt_ff) |=> state_ff == ST_IDLE)
      else $error("dump did not finish on its last entry");
`endif

endmodule
`default_nettype wire
